@@ design/tilt_gesture_detector_defines.svh @@
// ---------------------------------------------------------------------------
// Tilt gesture detector assertion macros
// Shared property wrappers for the tilt gesture detector RTL.
// ---------------------------------------------------------------------------
`ifndef TILT_GESTURE_DETECTOR_DEFINES_SVH
`define TILT_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tgd_pkg.sv @@
// ---------------------------------------------------------------------------
// Tilt gesture detector package
// Widths, codes, state types and the change classifier.
// ---------------------------------------------------------------------------
`default_nettype none

package tgd_pkg;

  // History ring geometry
  localparam int HISTORY_DEPTH = 20;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int STEP_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int DUR_W         = $clog2(HISTORY_DEPTH + 2);
  localparam int WS_W          = STEP_W + 1;
  localparam int SUM_W         = $clog2(3 * HISTORY_DEPTH);

  // Field widths
  localparam int ANGLE_W    = 13;
  localparam int LEVEL_W    = 10;
  localparam int TICKS_W    = 5;
  localparam int CLASS_W    = 3;
  localparam int GESTURE_W  = 2;
  localparam int DIFF_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int CMP_W      = (DUR_W > TICKS_W) ? DUR_W : TICKS_W;

  // Heading seam handling, 1/16 degree
  localparam logic [ANGLE_W-1:0]       SEAM_LOW  = 13'd1440;
  localparam logic [ANGLE_W-1:0]       SEAM_HIGH = 13'd4320;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 16'sd5760;

  // Register reset values
  localparam logic [LEVEL_W-1:0] JITTER_RST = 10'd32;
  localparam logic [LEVEL_W-1:0] CHANGE_RST = 10'd64;
  localparam logic [LEVEL_W-1:0] FAST_RST   = 10'd96;
  localparam logic [TICKS_W-1:0] RETURN_RST = 5'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JITTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETURN = 2'd3;

  // Change classes
  localparam logic [CLASS_W-1:0] CLS_STABLE     = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_JITTER     = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_RAISE      = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_RAISE_FAST = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_FALL       = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_FALL_FAST  = 3'd5;

  // Gesture codes
  localparam logic [GESTURE_W-1:0] GEST_NONE = 2'd0;
  localparam logic [GESTURE_W-1:0] GEST_POS  = 2'd1;
  localparam logic [GESTURE_W-1:0] GEST_NEG  = 2'd2;

  // Walk start markers
  localparam logic signed [WS_W-1:0] WS_MINUS1 = WS_W'(-1);
  localparam logic signed [WS_W-1:0] WS_MINUS2 = WS_W'(-2);
  localparam logic signed [WS_W-1:0] WS_DEPTH  = WS_W'(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    G_IDLE,
    G_BEGIN,
    G_POS_MOVE,
    G_PEAK,
    G_FALLBACK,
    G_POS_HIT,
    G_NEG_MOVE,
    G_TROUGH,
    G_RISEBACK,
    G_NEG_HIT
  } gest_state_t;

  // Class one axis change against the three levels
  function automatic logic [CLASS_W-1:0] classify(
    input logic signed [DIFF_W-1:0] d,
    input logic [LEVEL_W-1:0]       jit,
    input logic [LEVEL_W-1:0]       chg,
    input logic [LEVEL_W-1:0]       fst
  );
    logic signed [DIFF_W-1:0] mag;
    logic signed [DIFF_W-1:0] jit_s;
    logic signed [DIFF_W-1:0] chg_s;
    logic signed [DIFF_W-1:0] fst_s;
    logic [CLASS_W-1:0]       c;
    mag   = d[DIFF_W-1] ? -d : d;
    jit_s = $signed({{(DIFF_W-LEVEL_W){1'b0}}, jit});
    chg_s = $signed({{(DIFF_W-LEVEL_W){1'b0}}, chg});
    fst_s = $signed({{(DIFF_W-LEVEL_W){1'b0}}, fst});
    c = (d > chg_s) ? CLS_RAISE : CLS_JITTER;
    if (mag < jit_s) c = CLS_STABLE;
    if (d < -chg_s) c = CLS_FALL;
    if (mag > fst_s) c = c + CLASS_W'(1);
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/tgd_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/tilt_gesture_detector.sv @@
// Sequence: an accepted sample passes S_IDLE -> S_FINISH -> output register without
//   detection; with detection S_SETUP, then S_WALK over N = 1 .. HISTORY_DEPTH + 1
//   history entries, then S_FINISH. A new sample is taken only back in S_IDLE.
//   The walk reads one history entry per cycle; S_FINISH holds while the output stalls.
// Reset: configuration and control registers to defaults, history valid bits cleared
//   (entries read as stable), RAM contents left as they are.
// ---------------------------------------------------------------------------
// Tilt gesture detector
// Classes orientation changes, logs pitch classes in a RAM ring and walks
// them through a gesture state machine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tilt_gesture_detector_defines.svh"

module tilt_gesture_detector
  import tgd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ANGLE_W-1:0]   roll_angle,
  input  logic signed [ANGLE_W-1:0]   pitch_angle,
  input  logic [ANGLE_W-1:0]          heading_angle,
  input  logic                        detect_enable,
  input  logic                        clear_history,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CLASS_W-1:0]          roll_class,
  output logic [CLASS_W-1:0]          pitch_class,
  output logic [CLASS_W-1:0]          yaw_class,
  output logic [GESTURE_W-1:0]        gesture
);

  // Configuration registers
  logic [LEVEL_W-1:0] jitter_level;
  logic [LEVEL_W-1:0] change_level;
  logic [LEVEL_W-1:0] fast_level;
  logic [TICKS_W-1:0] min_return_ticks;

  // Control
  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        in_fire;
  logic        out_load;
  logic        walk_last;

  // Sample state
  logic signed [ANGLE_W-1:0] prev_roll;
  logic signed [ANGLE_W-1:0] prev_pitch;
  logic [ANGLE_W-1:0]        prev_heading;
  logic [CLASS_W-1:0]        cls_roll;
  logic [CLASS_W-1:0]        cls_pitch;
  logic [CLASS_W-1:0]        cls_yaw;
  logic                      clr_req;
  logic [GESTURE_W-1:0]      gest_code;

  // History ring
  logic [HIST_AW-1:0]        hist_ptr;
  logic [HIST_AW-1:0]        ptr_inc;
  logic [HISTORY_DEPTH-1:0]  hist_valid;
  logic [HIST_AW-1:0]        ram_raddr;
  logic [CLASS_W-1:0]        ram_rdata;

  // Walk
  gest_state_t               gst;
  gest_state_t               gst_next;
  logic signed [WS_W-1:0]    walk_start;
  logic signed [WS_W-1:0]    ws_next;
  logic signed [WS_W-1:0]    ws_fin;
  logic [STEP_W-1:0]         step;
  logic [STEP_W-1:0]         step_init;
  logic [DUR_W-1:0]          dur;
  logic [DUR_W-1:0]          dur_next;
  logic [HIST_AW-1:0]        rd_addr;
  logic [HIST_AW-1:0]        addr_inc;
  logic [HIST_AW-1:0]        start_addr;
  logic [SUM_W-1:0]          start_sum;
  logic [CLASS_W-1:0]        p;
  logic                      stop;

  // Classifier datapath
  logic signed [DIFF_W-1:0]  roll_d;
  logic signed [DIFF_W-1:0]  pitch_d;
  logic signed [DIFF_W-1:0]  yaw_d;
  logic signed [DIFF_W-1:0]  head_cur;
  logic signed [DIFF_W-1:0]  head_prev;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_level     <= JITTER_RST;
      change_level     <= CHANGE_RST;
      fast_level       <= FAST_RST;
      min_return_ticks <= RETURN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_JITTER: jitter_level     <= cfg_data;
        REG_CHANGE: change_level     <= cfg_data;
        REG_FAST:   fast_level       <= cfg_data;
        REG_RETURN: min_return_ticks <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Unwrap heading at the seam and form the three changes
  always_comb begin
    head_cur  = $signed({{(DIFF_W-ANGLE_W){1'b0}}, heading_angle});
    head_prev = $signed({{(DIFF_W-ANGLE_W){1'b0}}, prev_heading});
    if (heading_angle < SEAM_LOW && prev_heading > SEAM_HIGH) begin
      head_prev = head_prev - FULL_TURN;
    end else if (heading_angle > SEAM_HIGH && prev_heading < SEAM_LOW) begin
      head_prev = head_prev + FULL_TURN;
    end
    roll_d  = $signed({{(DIFF_W-ANGLE_W){roll_angle[ANGLE_W-1]}}, roll_angle})
            - $signed({{(DIFF_W-ANGLE_W){prev_roll[ANGLE_W-1]}}, prev_roll});
    pitch_d = $signed({{(DIFF_W-ANGLE_W){pitch_angle[ANGLE_W-1]}}, pitch_angle})
            - $signed({{(DIFF_W-ANGLE_W){prev_pitch[ANGLE_W-1]}}, prev_pitch});
    yaw_d   = head_cur - head_prev;
  end

  // Ring pointer and walk address arithmetic
  always_comb begin
    ptr_inc  = (hist_ptr == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : hist_ptr + HIST_AW'(1);
    addr_inc = (rd_addr == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr + HIST_AW'(1);
    step_init = walk_start[WS_W-1] ? '0 : walk_start[STEP_W-1:0];
    // entry (ptr - 1 - step) modulo depth
    start_sum = SUM_W'(hist_ptr) + SUM_W'(2 * HISTORY_DEPTH - 1) - SUM_W'(step_init);
    if (start_sum >= SUM_W'(2 * HISTORY_DEPTH)) begin
      start_sum = start_sum - SUM_W'(2 * HISTORY_DEPTH);
    end else if (start_sum >= SUM_W'(HISTORY_DEPTH)) begin
      start_sum = start_sum - SUM_W'(HISTORY_DEPTH);
    end
    start_addr = start_sum[HIST_AW-1:0];
    ram_raddr  = (state == S_SETUP) ? start_addr : addr_inc;
  end

  // Pitch class history, one entry per sample
  tgd_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (ptr_inc),
    .wdata (classify(pitch_d, jitter_level, change_level, fast_level)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Evaluate one history entry in the gesture machine
  always_comb begin
    p = (step == STEP_W'(HISTORY_DEPTH) || !hist_valid[rd_addr]) ? CLS_STABLE : ram_rdata;
    gst_next = gst;
    ws_next  = walk_start;
    dur_next = dur + DUR_W'(1);
    stop     = 1'b0;
    case (gst)
      G_IDLE: begin
        if (p != CLS_STABLE) begin
          stop    = 1'b1;
          ws_next = WS_MINUS2;
        end else begin
          gst_next = G_BEGIN;
          ws_next  = WS_MINUS1;
        end
      end
      G_BEGIN: begin
        if (p == CLS_RAISE) begin
          gst_next = G_POS_MOVE;
          ws_next  = $signed({1'b0, step});
        end else if (p == CLS_FALL) begin
          gst_next = G_NEG_MOVE;
          ws_next  = $signed({1'b0, step});
        end else begin
          ws_next = WS_MINUS1;
        end
        dur_next = '0;
      end
      G_NEG_MOVE: begin
        if (p inside {CLS_STABLE, CLS_JITTER, CLS_RAISE, CLS_RAISE_FAST}) gst_next = G_TROUGH;
      end
      G_POS_MOVE: begin
        if (p inside {CLS_STABLE, CLS_JITTER, CLS_FALL, CLS_FALL_FAST}) gst_next = G_PEAK;
      end
      G_PEAK: begin
        if (p == CLS_FALL) gst_next = G_FALLBACK;
      end
      G_TROUGH: begin
        if (p == CLS_RAISE) gst_next = G_RISEBACK;
      end
      G_RISEBACK, G_FALLBACK: begin
        if (p == CLS_STABLE) begin
          if (CMP_W'(dur_next) > CMP_W'(min_return_ticks)) begin
            gst_next = (gst == G_FALLBACK) ? G_POS_HIT : G_NEG_HIT;
          end
          stop    = 1'b1;
          ws_next = WS_MINUS2;
        end
      end
      default: begin
        gst_next = G_IDLE;
        stop     = 1'b1;
      end
    endcase
    walk_last = stop || (step == '0);
    ws_fin    = (ws_next < WS_DEPTH) ? ws_next + WS_W'(1) : WS_MINUS1;
  end

  // Control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = detect_enable ? S_SETUP : S_FINISH;
      end
      S_SETUP: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        if (walk_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        out_load = !out_valid || out_ready;
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // Ring pointer, valid bits, walk start and previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_ptr   <= '0;
      hist_valid <= '0;
      walk_start <= '0;
      prev_roll    <= '0;
      prev_pitch   <= '0;
      prev_heading <= '0;
    end else begin
      if (in_fire) begin
        hist_ptr            <= ptr_inc;
        hist_valid[ptr_inc] <= 1'b1;
        prev_roll           <= roll_angle;
        prev_pitch          <= pitch_angle;
        prev_heading        <= heading_angle;
      end
      if (state == S_SETUP && walk_start[WS_W-1]) begin
        walk_start <= '0;
      end
      if (state == S_WALK) begin
        walk_start <= walk_last ? ws_fin : ws_next;
      end
      // drop history after a hit or on request
      if (out_load && (clr_req || gest_code != GEST_NONE)) begin
        hist_ptr   <= '0;
        hist_valid <= '0;
      end
    end
  end

  // Capture sample results and advance the walk
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cls_roll  <= classify(roll_d, jitter_level, change_level, fast_level);
      cls_pitch <= classify(pitch_d, jitter_level, change_level, fast_level);
      cls_yaw   <= classify(yaw_d, jitter_level, change_level, fast_level);
      clr_req   <= clear_history;
      gest_code <= GEST_NONE;
    end
    if (state == S_SETUP) begin
      gst     <= walk_start[WS_W-1] ? G_IDLE : G_BEGIN;
      step    <= step_init;
      dur     <= '0;
      rd_addr <= start_addr;
    end
    if (state == S_WALK) begin
      gst     <= gst_next;
      step    <= step - STEP_W'(1);
      dur     <= dur_next;
      rd_addr <= addr_inc;
      if (walk_last) begin
        gest_code <= (gst_next == G_POS_HIT) ? GEST_POS :
                     (gst_next == G_NEG_HIT) ? GEST_NEG : GEST_NONE;
      end
    end
  end

  // Output register, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      roll_class  <= cls_roll;
      pitch_class <= cls_pitch;
      yaw_class   <= cls_yaw;
      gesture     <= gest_code;
    end
  end

  `TGD_ASSERT_NEXT(a_hit_clears, out_load && gest_code != GEST_NONE, hist_valid == '0 && hist_ptr == '0, "history not cleared after gesture")
  `TGD_ASSERT_NEXT(a_walk_steps, state == S_WALK && !walk_last, state == S_WALK && step == $past(step) - STEP_W'(1), "walk did not step back by one")
  `TGD_ASSERT_NOW(a_start_range, state == S_IDLE, walk_start >= WS_MINUS1 && walk_start <= WS_DEPTH, "walk start out of range")
  `TGD_ASSERT_NOW(a_gest_code, out_valid, gesture == GEST_NONE || gesture == GEST_POS || gesture == GEST_NEG, "bad gesture code")

endmodule

`default_nettype wire
